/* hdl/assert_macros.svh */
// Shared assertion macros for the key-value table checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define KVT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("key_value_table assertion failed");

// Check a property on every rising edge, reset included.
`define KVT_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("key_value_table assertion failed");

`endif

/* hdl/kvt_pkg.sv */
package kvt_pkg;

  // Table geometry.
  localparam int Capacity = 16;
  localparam int KeyW     = 32;
  localparam int ValW     = 32;
  localparam int CntW     = $clog2(Capacity + 1);

  // Fixed port widths.
  localparam int CmdPortW = 3;
  localparam int KeyPortW = 32;
  localparam int ValPortW = 32;
  localparam int PosPortW = 4;
  localparam int StsPortW = 2;
  localparam int CntPortW = 5;

  typedef enum logic [CmdPortW-1:0] {
    CMD_INSERT   = 3'd0,
    CMD_UPDATE   = 3'd1,
    CMD_UPSERT   = 3'd2,
    CMD_ERASE    = 3'd3,
    CMD_LOOKUP   = 3'd4,
    CMD_READ_POS = 3'd5
  } kvt_cmd_t;

  typedef enum logic [StsPortW-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } kvt_status_t;

  // Per-cycle control broadcast to every cell.
  typedef struct packed {
    logic            push;   // shift toward older, new entry enters cell 0
    logic            erase;  // close the gap at the matching cell
    logic            upd;    // overwrite the value of the matching cell
    logic [ValW-1:0] value;
  } kvt_cell_ctl_t;

endpackage

/* hdl/kvt_cell.sv */
module kvt_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  kvt_pkg::kvt_cell_ctl_t        ctl,
  input  logic [kvt_pkg::KeyW-1:0]      cmp_key,
  input  logic                          left_valid,
  input  logic [kvt_pkg::KeyW-1:0]      left_key,
  input  logic [kvt_pkg::ValW-1:0]      left_value,
  input  logic                          right_valid,
  input  logic [kvt_pkg::KeyW-1:0]      right_key,
  input  logic [kvt_pkg::ValW-1:0]      right_value,
  input  logic                          hit_in,
  output logic                          hit_out,
  output logic                          match,
  output logic                          valid,
  output logic [kvt_pkg::KeyW-1:0]      key,
  output logic [kvt_pkg::ValW-1:0]      value
);

  logic                     valid_r, valid_nxt;
  logic [kvt_pkg::KeyW-1:0] key_r, key_nxt;
  logic [kvt_pkg::ValW-1:0] value_r, value_nxt;

  // Compare the stored key and pass the hit toward older cells.
  assign match   = valid_r && (key_r == cmp_key);
  assign hit_out = hit_in | match;

  // Pick next contents: shift in, shift out, or overwrite in place.
  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    if (ctl.push) begin
      valid_nxt = left_valid;
      key_nxt   = left_key;
      value_nxt = left_value;
    end else if (ctl.erase && hit_out) begin
      valid_nxt = right_valid;
      key_nxt   = right_key;
      value_nxt = right_value;
    end else if (ctl.upd && match) begin
      value_nxt = ctl.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      key_r   <= '0;
      value_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      key_r   <= key_nxt;
      value_r <= value_nxt;
    end
  end

  assign valid = valid_r;
  assign key   = key_r;
  assign value = value_r;

endmodule

/* hdl/key_value_table.sv */
// A result beat is registered and appears in the cycle after its command beat is accepted.
// Throughput: one command per cycle while no result beat is stalled; every command is one parallel key compare
// across the row of cells plus a one-step shift of that row.
// A command is accepted while the output register is empty or being drained.
// Reset (synchronous, active low) empties all cells, zeroes the entry count
// and drops any pending result beat.
module key_value_table (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [kvt_pkg::CmdPortW-1:0]    in_cmd,
  input  logic [kvt_pkg::KeyPortW-1:0]    in_key,
  input  logic [kvt_pkg::ValPortW-1:0]    in_value,
  input  logic [kvt_pkg::PosPortW-1:0]    in_position,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [kvt_pkg::StsPortW-1:0]    out_status,
  output logic [kvt_pkg::KeyPortW-1:0]    out_found_key,
  output logic [kvt_pkg::ValPortW-1:0]    out_found_value,
  output logic [kvt_pkg::CntPortW-1:0]    out_entry_count
);

  localparam int Cap = kvt_pkg::Capacity;

  logic                       in_fire;
  logic [kvt_pkg::KeyW-1:0]   cmd_key;
  logic [kvt_pkg::ValW-1:0]   cmd_value;
  kvt_pkg::kvt_cmd_t          cmd;
  kvt_pkg::kvt_cell_ctl_t     ctl;

  logic                       cell_valid [Cap];
  logic [kvt_pkg::KeyW-1:0]   cell_key   [Cap];
  logic [kvt_pkg::ValW-1:0]   cell_value [Cap];
  logic                       cell_match [Cap];
  logic [Cap:0]               hit_chain;

  logic                       any_hit;
  logic [kvt_pkg::ValW-1:0]   hit_value;
  logic [kvt_pkg::KeyW-1:0]   pos_key;
  logic [kvt_pkg::ValW-1:0]   pos_value;
  logic                       pos_ok;
  logic                       full;

  logic [kvt_pkg::CntW-1:0]   count_r, count_nxt;
  logic                       out_valid_r, out_valid_nxt;
  kvt_pkg::kvt_status_t       status_r, status_nxt;
  logic [kvt_pkg::KeyW-1:0]   fkey_r, fkey_nxt;
  logic [kvt_pkg::ValW-1:0]   fvalue_r, fvalue_nxt;

  // Take a beat when the output register is free or drains this cycle.
  assign in_stall  = out_valid_r & out_stall;
  assign in_fire   = in_valid & ~in_stall;
  assign cmd_key   = kvt_pkg::KeyW'(in_key);
  assign cmd_value = kvt_pkg::ValW'(in_value);
  assign cmd       = kvt_pkg::kvt_cmd_t'(in_cmd);
  assign full      = (32'(count_r) == 32'(Cap));

  // Row of cells, newest entry in cell 0.
  assign hit_chain[0] = 1'b0;
  for (genvar i = 0; i < Cap; i++) begin : g_cell
    logic                     lv, rv;
    logic [kvt_pkg::KeyW-1:0] lk, rk;
    logic [kvt_pkg::ValW-1:0] lval, rval;
    if (i == 0) begin : g_head
      assign lv   = 1'b1;
      assign lk   = cmd_key;
      assign lval = cmd_value;
    end else begin : g_mid
      assign lv   = cell_valid[i-1];
      assign lk   = cell_key[i-1];
      assign lval = cell_value[i-1];
    end
    if (i == Cap - 1) begin : g_tail
      assign rv   = 1'b0;
      assign rk   = '0;
      assign rval = '0;
    end else begin : g_body
      assign rv   = cell_valid[i+1];
      assign rk   = cell_key[i+1];
      assign rval = cell_value[i+1];
    end
    kvt_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .cmp_key     (cmd_key),
      .left_valid  (lv),
      .left_key    (lk),
      .left_value  (lval),
      .right_valid (rv),
      .right_key   (rk),
      .right_value (rval),
      .hit_in      (hit_chain[i]),
      .hit_out     (hit_chain[i+1]),
      .match       (cell_match[i]),
      .valid       (cell_valid[i]),
      .key         (cell_key[i]),
      .value       (cell_value[i])
    );
  end
  assign any_hit = hit_chain[Cap];

  // Gather the matching value and the entry at the requested position.
  always_comb begin
    hit_value = '0;
    pos_key   = '0;
    pos_value = '0;
    for (int i = 0; i < Cap; i++) begin
      if (cell_match[i]) hit_value = hit_value | cell_value[i];
      if (32'(in_position) == 32'(i)) begin
        pos_key   = cell_key[i];
        pos_value = cell_value[i];
      end
    end
  end
  assign pos_ok = (32'(in_position) < 32'(count_r));

  // Decode the command into cell control and the result beat.
  always_comb begin
    ctl        = '0;
    ctl.value  = cmd_value;
    status_nxt = kvt_pkg::ST_MISS;
    fkey_nxt   = '0;
    fvalue_nxt = '0;
    case (cmd)
      kvt_pkg::CMD_INSERT: begin
        if (any_hit) begin
          status_nxt = kvt_pkg::ST_MISS;
        end else if (full) begin
          status_nxt = kvt_pkg::ST_FULL;
        end else begin
          ctl.push   = in_fire;
          status_nxt = kvt_pkg::ST_OK;
        end
      end
      kvt_pkg::CMD_UPDATE: begin
        if (any_hit) begin
          ctl.upd    = in_fire;
          status_nxt = kvt_pkg::ST_OK;
        end
      end
      kvt_pkg::CMD_UPSERT: begin
        if (any_hit) begin
          ctl.upd    = in_fire;
          status_nxt = kvt_pkg::ST_OK;
        end else if (full) begin
          status_nxt = kvt_pkg::ST_FULL;
        end else begin
          ctl.push   = in_fire;
          status_nxt = kvt_pkg::ST_OK;
        end
      end
      kvt_pkg::CMD_ERASE: begin
        if (any_hit) begin
          ctl.erase  = in_fire;
          status_nxt = kvt_pkg::ST_OK;
        end
      end
      kvt_pkg::CMD_LOOKUP: begin
        if (any_hit) begin
          fvalue_nxt = hit_value;
          status_nxt = kvt_pkg::ST_OK;
        end
      end
      kvt_pkg::CMD_READ_POS: begin
        if (pos_ok) begin
          fkey_nxt   = pos_key;
          fvalue_nxt = pos_value;
          status_nxt = kvt_pkg::ST_OK;
        end
      end
      default: begin
        status_nxt = kvt_pkg::ST_MISS;
      end
    endcase
  end

  // Advance the entry count with the row.
  always_comb begin
    count_nxt = count_r;
    if (ctl.push) begin
      count_nxt = count_r + kvt_pkg::CntW'(1);
    end else if (ctl.erase) begin
      count_nxt = count_r - kvt_pkg::CntW'(1);
    end
  end

  // Hold a result beat until it is taken.
  assign out_valid_nxt = in_fire | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r <= status_nxt;
      fkey_r   <= fkey_nxt;
      fvalue_r <= fvalue_nxt;
    end
  end

  logic [kvt_pkg::CntW-1:0] count_out_r;
  always_ff @(posedge clk) begin
    if (in_fire) begin
      count_out_r <= count_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_found_key   = kvt_pkg::KeyPortW'(fkey_r);
  assign out_found_value = kvt_pkg::ValPortW'(fvalue_r);
  assign out_entry_count = kvt_pkg::CntPortW'(count_out_r);

endmodule

/* hdl/kvt_checker.sv */
`include "assert_macros.svh"

module kvt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic [kvt_pkg::CmdPortW-1:0]    in_cmd,
  input logic [kvt_pkg::KeyPortW-1:0]    in_key,
  input logic [kvt_pkg::ValPortW-1:0]    in_value,
  input logic [kvt_pkg::PosPortW-1:0]    in_position,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [kvt_pkg::StsPortW-1:0]    out_status,
  input logic [kvt_pkg::KeyPortW-1:0]    out_found_key,
  input logic [kvt_pkg::ValPortW-1:0]    out_found_value,
  input logic [kvt_pkg::CntPortW-1:0]    out_entry_count
);

  // A stalled result beat holds.
  `KVT_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_found_key) && $stable(out_found_value) && $stable(out_entry_count))

  // Reset drops any pending result.
  `KVT_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

  // The count never exceeds the capacity.
  `KVT_ASSERT(a_count_bound, clk, rst_n, out_valid |-> 32'(out_entry_count) <= 32'(kvt_pkg::Capacity))

  // A full refusal only happens at capacity.
  `KVT_ASSERT(a_full_at_cap, clk, rst_n, out_valid && out_status == kvt_pkg::ST_FULL |-> 32'(out_entry_count) == 32'(kvt_pkg::Capacity))

  // A failed command reports no key or value.
  `KVT_ASSERT(a_fail_zero, clk, rst_n, out_valid && out_status != kvt_pkg::ST_OK |-> out_found_key == '0 && out_found_value == '0)

endmodule

bind key_value_table kvt_checker u_kvt_checker (.*);

/* sim/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Command codes the package leaves unnamed; the table must refuse them
  localparam logic [kvt_pkg::CmdPortW-1:0] CMD_RSVD_6 = 3'd6;
  localparam logic [kvt_pkg::CmdPortW-1:0] CMD_RSVD_7 = 3'd7;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 185;
  localparam int POOL_SIZE    = 24;
  localparam int MAX_REPORTED = 10;

  typedef enum int {MIX_FILL, MIX_CHURN, MIX_DRAIN, MIX_NOISE} cmd_mix_t;

  typedef struct {
    kvt_pkg::kvt_status_t           status;
    logic [kvt_pkg::KeyPortW-1:0]   key;
    logic [kvt_pkg::ValPortW-1:0]   value;
    logic [kvt_pkg::CntPortW-1:0]   count;
  } table_result_t;

  typedef struct {
    logic [kvt_pkg::CmdPortW-1:0]   cmd;
    logic [kvt_pkg::KeyPortW-1:0]   key;
    logic [kvt_pkg::ValPortW-1:0]   value;
    logic [kvt_pkg::PosPortW-1:0]   pos;
    bit                             typed;
    table_result_t                  want;
  } directed_row_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [kvt_pkg::CmdPortW-1:0]   in_cmd = '0;
  logic [kvt_pkg::KeyPortW-1:0]   in_key = '0;
  logic [kvt_pkg::ValPortW-1:0]   in_value = '0;
  logic [kvt_pkg::PosPortW-1:0]   in_position = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [kvt_pkg::StsPortW-1:0]   out_status;
  logic [kvt_pkg::KeyPortW-1:0]   out_found_key;
  logic [kvt_pkg::ValPortW-1:0]   out_found_value;
  logic [kvt_pkg::CntPortW-1:0]   out_entry_count;

  // Shadow copy of the table, newest entry at index 0
  logic [kvt_pkg::KeyW-1:0]       shadow_key [kvt_pkg::Capacity];
  logic [kvt_pkg::ValW-1:0]       shadow_val [kvt_pkg::Capacity];
  int                             shadow_count = 0;

  table_result_t                  awaited_results [$];
  directed_row_t                  directed_rows [$];
  logic [kvt_pkg::KeyPortW-1:0]   key_pool [POOL_SIZE];
  int                             fail_count = 0;
  int                             cycle_count = 0;
  int                             stall_left = 0;
  bit                             gaps_on = 1'b0;

  key_value_table dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_key          (in_key),
    .in_value        (in_value),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_found_key   (out_found_key),
    .out_found_value (out_found_value),
    .out_entry_count (out_entry_count)
  );

  always #5 clk = ~clk;

  // Apply one command to the shadow table and return the result it yields
  function automatic table_result_t apply_command(
      logic [kvt_pkg::CmdPortW-1:0] cmd,
      logic [kvt_pkg::KeyPortW-1:0] key,
      logic [kvt_pkg::ValPortW-1:0] value,
      logic [kvt_pkg::PosPortW-1:0] pos);
    table_result_t r;
    int hit;
    int i;
    r = '{kvt_pkg::ST_MISS, '0, '0, '0};
    hit = -1;
    for (i = 0; i < shadow_count; i++) begin
      if (hit < 0 && shadow_key[i] == key) hit = i;
    end
    case (cmd)
      kvt_pkg::CMD_INSERT, kvt_pkg::CMD_UPSERT: begin
        if (hit >= 0) begin
          if (cmd == kvt_pkg::CMD_UPSERT) begin
            shadow_val[hit] = value;
            r.status = kvt_pkg::ST_OK;
          end
        end else if (shadow_count >= kvt_pkg::Capacity) begin
          r.status = kvt_pkg::ST_FULL;
        end else begin
          // shift older entries down, new one enters at the front
          for (i = shadow_count; i > 0; i--) begin
            shadow_key[i] = shadow_key[i-1];
            shadow_val[i] = shadow_val[i-1];
          end
          shadow_key[0] = key;
          shadow_val[0] = value;
          shadow_count++;
          r.status = kvt_pkg::ST_OK;
        end
      end
      kvt_pkg::CMD_UPDATE: begin
        if (hit >= 0) begin
          shadow_val[hit] = value;
          r.status = kvt_pkg::ST_OK;
        end
      end
      kvt_pkg::CMD_ERASE: begin
        if (hit >= 0) begin
          // close the gap
          for (i = hit; i + 1 < shadow_count; i++) begin
            shadow_key[i] = shadow_key[i+1];
            shadow_val[i] = shadow_val[i+1];
          end
          shadow_count--;
          shadow_key[shadow_count] = '0;
          shadow_val[shadow_count] = '0;
          r.status = kvt_pkg::ST_OK;
        end
      end
      kvt_pkg::CMD_LOOKUP: begin
        if (hit >= 0) begin
          r.value  = shadow_val[hit];
          r.status = kvt_pkg::ST_OK;
        end
      end
      kvt_pkg::CMD_READ_POS: begin
        if (pos < shadow_count) begin
          r.key    = shadow_key[pos];
          r.value  = shadow_val[pos];
          r.status = kvt_pkg::ST_OK;
        end
      end
      default: ;
    endcase
    r.count = shadow_count[kvt_pkg::CntPortW-1:0];
    return r;
  endfunction

  // Hand one command beat to the table, with an optional idle burst first
  task automatic send_command(logic [kvt_pkg::CmdPortW-1:0] cmd,
                              logic [kvt_pkg::KeyPortW-1:0] key,
                              logic [kvt_pkg::ValPortW-1:0] value,
                              logic [kvt_pkg::PosPortW-1:0] pos,
                              bit typed, table_result_t typed_res);
    int gap;
    table_result_t predicted;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    in_cmd      <= cmd;
    in_key      <= key;
    in_value    <= value;
    in_position <= pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = apply_command(cmd, key, value, pos);
    awaited_results.push_back(typed ? typed_res : predicted);
  endtask

  // Drop valid and hold until every outstanding result has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(logic [kvt_pkg::CmdPortW-1:0] cmd,
                         logic [kvt_pkg::KeyPortW-1:0] key,
                         logic [kvt_pkg::ValPortW-1:0] value,
                         logic [kvt_pkg::PosPortW-1:0] pos,
                         bit typed, kvt_pkg::kvt_status_t st,
                         logic [kvt_pkg::KeyPortW-1:0] fk,
                         logic [kvt_pkg::ValPortW-1:0] fv,
                         logic [kvt_pkg::CntPortW-1:0] cnt);
    directed_row_t row;
    row.cmd   = cmd;
    row.key   = key;
    row.value = value;
    row.pos   = pos;
    row.typed = typed;
    row.want  = '{st, fk, fv, cnt};
    directed_rows.push_back(row);
  endtask

  // Mostly keys from a small pool so hits, conflicts and a full table occur
  function automatic logic [kvt_pkg::KeyPortW-1:0] pick_key(bit prefer_present);
    if (prefer_present && shadow_count > 0 && $urandom_range(0, 9) < 6)
      return shadow_key[$urandom_range(0, shadow_count - 1)];
    if ($urandom_range(0, 19) < 17)
      return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic logic [kvt_pkg::CmdPortW-1:0] pick_cmd(cmd_mix_t mix);
    int r;
    r = $urandom_range(0, 9);
    case (mix)
      MIX_FILL: begin
        if (r < 5) return kvt_pkg::CMD_INSERT;
        if (r < 7) return kvt_pkg::CMD_UPSERT;
        if (r == 7) return kvt_pkg::CMD_LOOKUP;
        if (r == 8) return kvt_pkg::CMD_READ_POS;
        return kvt_pkg::CMD_UPDATE;
      end
      MIX_DRAIN: begin
        if (r < 5) return kvt_pkg::CMD_ERASE;
        if (r == 5) return kvt_pkg::CMD_LOOKUP;
        if (r == 6) return kvt_pkg::CMD_READ_POS;
        if (r == 7) return kvt_pkg::CMD_UPDATE;
        if (r == 8) return kvt_pkg::CMD_INSERT;
        return kvt_pkg::CMD_UPSERT;
      end
      MIX_CHURN: return kvt_pkg::kvt_cmd_t'($urandom_range(0, 5));
      default:   return kvt_pkg::CmdPortW'($urandom_range(0, 7));
    endcase
  endfunction

  // Result stall: random bursts while gaps are on
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin : check_result
    table_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTED)
          $display("%0t: result beat with nothing outstanding: status=%0d key=%h",
                   $time, out_status, out_found_key,
                   " value=%h count=%0d", out_found_value, out_entry_count);
      end else begin
        want = awaited_results.pop_front();
        if (out_status !== want.status || out_found_key !== want.key ||
            out_found_value !== want.value || out_entry_count !== want.count) begin
          fail_count++;
          if (fail_count <= MAX_REPORTED)
            $display("%0t: mismatch: expected status=%0d key=%h value=%h count=%0d,",
                     $time, want.status, want.key, want.value, want.count,
                     " got status=%0d key=%h value=%h count=%0d",
                     out_status, out_found_key, out_found_value, out_entry_count);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[key_value_table] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    table_result_t none;
    logic [kvt_pkg::CmdPortW-1:0] cmd;
    logic [kvt_pkg::KeyPortW-1:0] key;
    logic [kvt_pkg::PosPortW-1:0] pos;
    cmd_mix_t mix;
    none = '{kvt_pkg::ST_OK, '0, '0, '0};
    for (int i = 0; i < kvt_pkg::Capacity; i++) begin
      shadow_key[i] = '0;
      shadow_val[i] = '0;
    end
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    // Empty table, key and value extremes, conflicts, every command
    add_row(kvt_pkg::CMD_READ_POS, '0, '0, 4'd0, 1, kvt_pkg::ST_MISS, '0, '0, 5'd0);
    add_row(kvt_pkg::CMD_LOOKUP, '0, '1, 4'd0, 1, kvt_pkg::ST_MISS, '0, '0, 5'd0);
    add_row(kvt_pkg::CMD_ERASE, '1, '0, 4'd15, 1, kvt_pkg::ST_MISS, '0, '0, 5'd0);
    add_row(kvt_pkg::CMD_UPDATE, '0, 32'd1, 4'd0, 1, kvt_pkg::ST_MISS, '0, '0, 5'd0);
    add_row(kvt_pkg::CMD_INSERT, '0, '1, 4'd0, 1, kvt_pkg::ST_OK, '0, '0, 5'd1);
    add_row(kvt_pkg::CMD_INSERT, '0, 32'd1, 4'd0, 1, kvt_pkg::ST_MISS, '0, '0, 5'd1);
    add_row(kvt_pkg::CMD_INSERT, '1, '0, 4'd0, 1, kvt_pkg::ST_OK, '0, '0, 5'd2);
    add_row(kvt_pkg::CMD_LOOKUP, '1, '1, 4'd0, 1, kvt_pkg::ST_OK, '0, '0, 5'd2);
    add_row(kvt_pkg::CMD_READ_POS, '0, '0, 4'd0, 1, kvt_pkg::ST_OK, '1, '0, 5'd2);
    add_row(kvt_pkg::CMD_READ_POS, '0, '0, 4'd1, 1, kvt_pkg::ST_OK, '0, '1, 5'd2);
    add_row(kvt_pkg::CMD_READ_POS, '0, '0, 4'd15, 1, kvt_pkg::ST_MISS, '0, '0, 5'd2);
    add_row(kvt_pkg::CMD_UPSERT, '0, 32'h1234_5678, 4'd0, 1,
            kvt_pkg::ST_OK, '0, '0, 5'd2);
    add_row(kvt_pkg::CMD_UPSERT, 32'h5a5a_5a5a, 32'ha5a5_a5a5, 4'd0, 1,
            kvt_pkg::ST_OK, '0, '0, 5'd3);
    add_row(kvt_pkg::CMD_UPDATE, '1, 32'hdead_beef, 4'd0, 1,
            kvt_pkg::ST_OK, '0, '0, 5'd3);
    add_row(CMD_RSVD_6, 32'h5a5a_5a5a, '1, 4'd0, 1, kvt_pkg::ST_MISS, '0, '0, 5'd3);
    add_row(CMD_RSVD_7, '1, '1, 4'd15, 1, kvt_pkg::ST_MISS, '0, '0, 5'd3);
    // erase from the middle, older entry moves up
    add_row(kvt_pkg::CMD_ERASE, '1, '0, 4'd0, 1, kvt_pkg::ST_OK, '0, '0, 5'd2);
    add_row(kvt_pkg::CMD_READ_POS, '0, '0, 4'd1, 1,
            kvt_pkg::ST_OK, '0, 32'h1234_5678, 5'd2);
    add_row(kvt_pkg::CMD_LOOKUP, 32'h5a5a_5a5a, '0, 4'd0, 0, kvt_pkg::ST_OK, '0, '0, '0);
    add_row(kvt_pkg::CMD_ERASE, '0, '0, 4'd0, 0, kvt_pkg::ST_OK, '0, '0, '0);
    add_row(kvt_pkg::CMD_READ_POS, '0, '0, 4'd2, 0, kvt_pkg::ST_OK, '0, '0, '0);
    add_row(kvt_pkg::CMD_ERASE, 32'h5a5a_5a5a, '0, 4'd0, 1, kvt_pkg::ST_OK, '0, '0, 5'd0);
    add_row(kvt_pkg::CMD_READ_POS, '0, '0, 4'd0, 1, kvt_pkg::ST_MISS, '0, '0, 5'd0);

    // Hold reset, release on a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    gaps_on = 1'b1;
    foreach (directed_rows[i])
      send_command(directed_rows[i].cmd, directed_rows[i].key, directed_rows[i].value,
                   directed_rows[i].pos, directed_rows[i].typed, directed_rows[i].want);
    drain_results();

    // Random phases: fill, churn, drain and noise mixes, quiet at the end
    for (int ph = 0; ph < PHASES; ph++) begin
      gaps_on = (ph % 3 != 2) && (ph < PHASES - 2);
      mix = cmd_mix_t'(ph % 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        cmd = pick_cmd(mix);
        key = pick_key(cmd == kvt_pkg::CMD_ERASE || cmd == kvt_pkg::CMD_UPDATE ||
                       cmd == kvt_pkg::CMD_LOOKUP);
        if (mix == MIX_NOISE && $urandom_range(0, 1) == 0) key = $urandom;
        if (shadow_count > 0 && $urandom_range(0, 9) < 7)
          pos = kvt_pkg::PosPortW'($urandom_range(0, shadow_count - 1));
        else
          pos = kvt_pkg::PosPortW'($urandom_range(0, 15));
        send_command(cmd, key, $urandom, pos, 0, none);
      end
      drain_results();
    end

    repeat (4) @(posedge clk);
    if (fail_count == 0 && awaited_results.size() == 0) begin
      $display("[key_value_table] OK");
    end else begin
      $display("[key_value_table] ERROR");
    end
    $finish;
  end

endmodule
